// ===== src/inverse_error_function_poly_macros.svh =====
// Assertion macros shared by the inverse error function RTL
`ifndef INVERSE_ERROR_FUNCTION_POLY_MACROS_SVH
`define INVERSE_ERROR_FUNCTION_POLY_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define IERF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define IERF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ierf_pkg.sv =====
// Package: formats, constants, coefficient tables and multiply helpers
`timescale 1ns / 1ps
`default_nettype none
package ierf_pkg;

    localparam int IN_FRAC_BITS  = 30;
    localparam int OUT_FRAC_BITS = 26;
    localparam int LOG_ITERS     = 48;
    localparam int SQRT_BITS     = 51;
    localparam int HORNER_STEPS  = 8;

    localparam logic [63:0] LN2_Q63   = 64'h58B90BFBE8E7BCD6;
    localparam logic [63:0] W_SPLIT   = 64'd5 << 48;
    localparam logic [63:0] T_LO_OFS  = 64'd5 << 47;
    localparam logic [63:0] T_HI_OFS  = 64'd3 << 48;

    localparam logic signed [63:0] POLY_LO [0:HORNER_STEPS] = '{
        64'sd7910084,
        64'sd96623024,
        -64'sd991745471,
        -64'sd1236099201,
        64'sd61515045290,
        -64'sd352892223620,
        -64'sd1175912842320,
        64'sd69423192888000,
        64'sd422609178712910
    };

    localparam logic signed [63:0] POLY_HI [0:HORNER_STEPS] = '{
        -64'sd56355303326,
        64'sd28415055962,
        64'sd379806351420,
        -64'sd1033978184580,
        64'sd1615527804630,
        -64'sd2145532116860,
        64'sd2656805845940,
        64'sd281946182710168,
        64'sd797412084430000
    };

    // Item data that rides alongside the arithmetic
    typedef struct packed {
        logic        neg;
        logic        sat;
        logic [29:0] a30;
    } side_t;

    // Four 32x32 partial products of a 64x64 multiply
    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } part_t;

    function automatic part_t part_mul(input logic [63:0] a, input logic [63:0] b);
        part_t r;
        r.p00 = a[31:0]  * b[31:0];
        r.p01 = a[31:0]  * b[63:32];
        r.p10 = a[63:32] * b[31:0];
        r.p11 = a[63:32] * b[63:32];
        return r;
    endfunction

    function automatic logic [127:0] part_sum(input part_t p);
        return {64'd0, p.p00} + ({64'd0, p.p01} << 32) + ({64'd0, p.p10} << 32)
             + {p.p11, 64'd0};
    endfunction

endpackage
`default_nettype wire

// ===== src/ierf_if.sv =====
// Channel interfaces for argument and result beats
`timescale 1ns / 1ps
`default_nettype none
interface ierf_arg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] arg_value;
    modport source (output valid, output arg_value, input ready);
    modport sink   (input valid, input arg_value, output ready);
endinterface

interface ierf_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               saturated;
    modport source (output valid, output result_value, output saturated, input ready);
    modport sink   (input valid, input result_value, input saturated, output ready);
endinterface
`default_nettype wire

// ===== src/ierf_log.sv =====
// Pipelined w = -ln(u / 2^60) in Q48 by repeated squaring
`timescale 1ns / 1ps
`default_nettype none
module ierf_log (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [60:0]     u,
    input  wire ierf_pkg::side_t in_side,
    output logic                 out_valid,
    output logic [63:0]          w,
    output ierf_pkg::side_t      out_side
);
    import ierf_pkg::*;

    function automatic logic [5:0] lead_pos(input logic [60:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 61; i++)
        begin
            if (v[i])
            begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // leading-one search stage
    logic        pv_reg;
    logic [60:0] pu_reg;
    logic [5:0]  ppos_reg;
    side_t       pside_reg;

    // squaring chain; index 0 is the normalized value
    logic        cv_reg    [0:LOG_ITERS];
    logic [63:0] cm_reg    [0:LOG_ITERS];
    logic [47:0] cfrac_reg [0:LOG_ITERS];
    logic [5:0]  ce_reg    [0:LOG_ITERS];
    side_t       cside_reg [0:LOG_ITERS];

    logic        mv_reg    [0:LOG_ITERS-1];
    part_t       mpart_reg [0:LOG_ITERS-1];
    logic [47:0] mfrac_reg [0:LOG_ITERS-1];
    logic [5:0]  me_reg    [0:LOG_ITERS-1];
    side_t       mside_reg [0:LOG_ITERS-1];

    // ln2 scaling
    logic        lv_reg;
    part_t       lpart_reg;
    side_t       lside_reg;
    logic        ov_reg;
    logic [63:0] ow_reg;
    side_t       oside_reg;

    logic [63:0] lg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            cv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            pv_reg    <= in_valid;
            cv_reg[0] <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pu_reg       <= u;
            ppos_reg     <= lead_pos(u);
            pside_reg    <= in_side;
            cm_reg[0]    <= 64'(pu_reg) << (6'd62 - ppos_reg);
            ce_reg[0]    <= 6'd60 - ppos_reg;
            cfrac_reg[0] <= '0;
            cside_reg[0] <= pside_reg;
        end
    end

    for (genvar i = 0; i < LOG_ITERS; i++)
    begin : g_iter
        logic [127:0] sq_full;
        logic [63:0]  sq;
        logic         hi;

        assign sq_full = part_sum(mpart_reg[i]);
        assign sq      = sq_full[125:62];
        assign hi      = sq[63];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[i]   <= 1'b0;
                cv_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                mv_reg[i]   <= cv_reg[i];
                cv_reg[i+1] <= mv_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mpart_reg[i]   <= part_mul(cm_reg[i], cm_reg[i]);
                mfrac_reg[i]   <= cfrac_reg[i];
                me_reg[i]      <= ce_reg[i];
                mside_reg[i]   <= cside_reg[i];
                cm_reg[i+1]    <= hi ? {1'b0, sq[63:1]} : sq;
                cfrac_reg[i+1] <= {mfrac_reg[i][46:0], hi};
                ce_reg[i+1]    <= me_reg[i];
                cside_reg[i+1] <= mside_reg[i];
            end
        end
    end

    assign lg = ({58'd0, ce_reg[LOG_ITERS]} << 48) - {16'd0, cfrac_reg[LOG_ITERS]};

    logic [127:0] lsum;
    assign lsum = part_sum(lpart_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            lv_reg <= cv_reg[LOG_ITERS];
            ov_reg <= lv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lpart_reg <= part_mul(lg, LN2_Q63);
            lside_reg <= cside_reg[LOG_ITERS];
            ow_reg    <= lsum[126:63];
            oside_reg <= lside_reg;
        end
    end

    assign out_valid = ov_reg;
    assign w         = ow_reg;
    assign out_side  = oside_reg;

endmodule
`default_nettype wire

// ===== src/ierf_sqrt.sv =====
// Pipelined floor square root in Q48, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ierf_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [63:0]                 w,
    input  wire ierf_pkg::side_t             in_side,
    output logic                             out_valid,
    output logic [ierf_pkg::SQRT_BITS-1:0]   root,
    output logic [63:0]                      out_w,
    output ierf_pkg::side_t                  out_side
);
    import ierf_pkg::*;

    logic         v_reg    [1:SQRT_BITS];
    logic [103:0] rem_reg  [1:SQRT_BITS];
    logic [50:0]  root_reg [1:SQRT_BITS];
    logic [63:0]  w_reg    [1:SQRT_BITS];
    side_t        side_reg [1:SQRT_BITS];

    // c*c >> 48 <= w  is  c*c <= w*2^48 + 2^48 - 1
    logic [103:0] n_in;
    assign n_in = ({40'd0, w} << 48) | {56'd0, 48'hFFFF_FFFF_FFFF};

    for (genvar k = 0; k < SQRT_BITS; k++)
    begin : g_bit
        localparam int B = SQRT_BITS - 1 - k;
        logic         v_src;
        logic [103:0] rem_src;
        logic [50:0]  root_src;
        logic [63:0]  w_src;
        side_t        side_src;
        logic [103:0] trial;
        logic         take;

        if (k == 0)
        begin : g_first
            assign v_src    = in_valid;
            assign rem_src  = n_in;
            assign root_src = '0;
            assign w_src    = w;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = v_reg[k];
            assign rem_src  = rem_reg[k];
            assign root_src = root_reg[k];
            assign w_src    = w_reg[k];
            assign side_src = side_reg[k];
        end

        assign trial = ({53'd0, root_src} << (B + 1)) + (104'd1 << (2 * B));
        assign take  = trial <= rem_src;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? rem_src - trial : rem_src;
                root_reg[k+1] <= take ? root_src | (51'd1 << B) : root_src;
                w_reg[k+1]    <= w_src;
                side_reg[k+1] <= side_src;
            end
        end
    end

    assign out_valid = v_reg[SQRT_BITS];
    assign root      = root_reg[SQRT_BITS];
    assign out_w     = w_reg[SQRT_BITS];
    assign out_side  = side_reg[SQRT_BITS];

endmodule
`default_nettype wire

// ===== src/ierf_horner.sv =====
// Pipelined degree-8 Horner evaluation, two stages per step
`timescale 1ns / 1ps
`default_nettype none
module ierf_horner (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic signed [63:0] t,
    input  wire logic               sel_hi,
    input  wire ierf_pkg::side_t    in_side,
    output logic                    out_valid,
    output logic signed [63:0]      p,
    output ierf_pkg::side_t         out_side
);
    import ierf_pkg::*;

    // chain index k holds p after k steps
    logic               cv_reg   [1:HORNER_STEPS];
    logic signed [63:0] cp_reg   [1:HORNER_STEPS];
    logic signed [63:0] ct_reg   [1:HORNER_STEPS];
    logic               csel_reg [1:HORNER_STEPS];
    side_t              cside_reg[1:HORNER_STEPS];

    logic               mv_reg   [1:HORNER_STEPS];
    part_t              mpart_reg[1:HORNER_STEPS];
    logic               mneg_reg [1:HORNER_STEPS];
    logic signed [63:0] mt_reg   [1:HORNER_STEPS];
    logic               msel_reg [1:HORNER_STEPS];
    side_t              mside_reg[1:HORNER_STEPS];

    for (genvar k = 1; k <= HORNER_STEPS; k++)
    begin : g_step
        logic               v_src;
        logic signed [63:0] p_src;
        logic signed [63:0] t_src;
        logic               sel_src;
        side_t              side_src;
        logic [63:0]        pm;
        logic [63:0]        tm;
        logic [127:0]       prod;
        logic [63:0]        r;
        logic signed [63:0] term;
        logic signed [63:0] coef;

        if (k == 1)
        begin : g_first
            assign v_src    = in_valid;
            assign p_src    = sel_hi ? POLY_HI[0] : POLY_LO[0];
            assign t_src    = t;
            assign sel_src  = sel_hi;
            assign side_src = in_side;
        end
        else
        begin : g_next
            assign v_src    = cv_reg[k-1];
            assign p_src    = cp_reg[k-1];
            assign t_src    = ct_reg[k-1];
            assign sel_src  = csel_reg[k-1];
            assign side_src = cside_reg[k-1];
        end

        assign pm   = p_src[63] ? 64'(-p_src) : 64'(p_src);
        assign tm   = t_src[63] ? 64'(-t_src) : 64'(t_src);
        assign prod = part_sum(mpart_reg[k]);
        assign r    = {1'b0, prod[110:48]};
        assign term = mneg_reg[k] ? -$signed(r) : $signed(r);
        assign coef = msel_reg[k] ? POLY_HI[k] : POLY_LO[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                mv_reg[k] <= 1'b0;
                cv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                mv_reg[k] <= v_src;
                cv_reg[k] <= mv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mpart_reg[k] <= part_mul(pm, tm);
                mneg_reg[k]  <= p_src[63] ^ t_src[63];
                mt_reg[k]    <= t_src;
                msel_reg[k]  <= sel_src;
                mside_reg[k] <= side_src;
                cp_reg[k]    <= coef + term;
                ct_reg[k]    <= mt_reg[k];
                csel_reg[k]  <= msel_reg[k];
                cside_reg[k] <= mside_reg[k];
            end
        end
    end

    assign out_valid = cv_reg[HORNER_STEPS];
    assign p         = cp_reg[HORNER_STEPS];
    assign out_side  = cside_reg[HORNER_STEPS];

endmodule
`default_nettype wire

// ===== src/inverse_error_function_poly.sv =====
// Top level: fixed-point inverse error function pipeline with output skid
`timescale 1ns / 1ps
`default_nettype none
`include "inverse_error_function_poly_macros.svh"
// Takes x in Q2.30 and returns erfinv(x) in Q6.26, one beat per cycle
// sustained while the output skid entry is empty.
// The latency is set by the logarithm (48 squaring steps of two stages
// each) and the square root (one stage per root bit, 51 bits). The
// polynomial branch is picked on w before the Horner chain, and only that
// branch is evaluated. |x| >= 1 returns full scale with saturated set. A two
// entry output buffer lets the pipe keep moving while a result waits.
module inverse_error_function_poly (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ierf_arg_if.sink    arg,
    ierf_res_if.source  res
);
    import ierf_pkg::*;

    logic en;

    // front: magnitude and saturation check
    logic        f0v_reg;
    side_t       f0side_reg;
    logic        f1v_reg;
    logic [60:0] f1u_reg;
    side_t       f1side_reg;

    logic [32:0] amag;
    logic        asat;
    side_t       side_next;

    assign amag = arg.arg_value[31] ? 33'(-{arg.arg_value[31], arg.arg_value})
                                    : {1'b0, arg.arg_value};
    assign asat = amag >= (33'd1 << IN_FRAC_BITS);

    always_comb
    begin
        side_next.neg = arg.arg_value[31];
        side_next.sat = asat;
        side_next.a30 = asat ? 30'd0 : 30'(amag << (30 - IN_FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0v_reg <= 1'b0;
            f1v_reg <= 1'b0;
        end
        else if (en)
        begin
            f0v_reg <= arg.valid;
            f1v_reg <= f0v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0side_reg <= side_next;
            f1u_reg    <= (61'd1 << 60) - 61'(f0side_reg.a30) * 61'(f0side_reg.a30);
            f1side_reg <= f0side_reg;
        end
    end

    logic        lv;
    logic [63:0] lw;
    side_t       lside;

    ierf_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f1v_reg),
        .u         (f1u_reg),
        .in_side   (f1side_reg),
        .out_valid (lv),
        .w         (lw),
        .out_side  (lside)
    );

    logic        sv;
    logic [50:0] sroot;
    logic [63:0] sw;
    side_t       sside;

    ierf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (lv),
        .w         (lw),
        .in_side   (lside),
        .out_valid (sv),
        .root      (sroot),
        .out_w     (sw),
        .out_side  (sside)
    );

    // branch select and polynomial variable
    logic               tv_reg;
    logic signed [63:0] t_reg;
    logic               tsel_reg;
    side_t              tside_reg;
    logic               lo_branch;

    assign lo_branch = sw < W_SPLIT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= 1'b0;
        end
        else if (en)
        begin
            tv_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= lo_branch ? $signed(sw - T_LO_OFS)
                                   : $signed({13'd0, sroot} - T_HI_OFS);
            tsel_reg  <= !lo_branch;
            tside_reg <= sside;
        end
    end

    logic               hv;
    logic signed [63:0] hp;
    side_t              hside;

    ierf_horner u_horner (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (tv_reg),
        .t         (t_reg),
        .sel_hi    (tsel_reg),
        .in_side   (tside_reg),
        .out_valid (hv),
        .p         (hp),
        .out_side  (hside)
    );

    // final scale by x: partials, then sum, truncate and clamp
    logic        xv_reg;
    part_t       xpart_reg;
    logic        xpneg_reg;
    side_t       xside_reg;
    logic [63:0] pmag;

    assign pmag = hp[63] ? 64'(-hp) : 64'(hp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xv_reg <= 1'b0;
        end
        else if (en)
        begin
            xv_reg <= hv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xpart_reg <= part_mul(pmag, {34'd0, hside.a30});
            xpneg_reg <= hp[63];
            xside_reg <= hside;
        end
    end

    logic [127:0] xsum;
    logic [63:0]  rm;
    logic         rneg;
    logic [31:0]  res_next;

    assign xsum = part_sum(xpart_reg);
    assign rm   = xsum[93:30] >> (48 - OUT_FRAC_BITS);
    assign rneg = (xpneg_reg != xside_reg.neg) && (rm != 64'd0);

    always_comb
    begin
        if (xside_reg.sat)
        begin
            res_next = xside_reg.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (rneg)
        begin
            res_next = (rm >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-rm[31:0]);
        end
        else
        begin
            res_next = (rm >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rm[31:0];
        end
    end

    // output register plus skid entry
    logic        out_valid_reg;
    logic [31:0] out_res_reg;
    logic        out_sat_reg;
    logic        skid_valid_reg;
    logic [31:0] skid_res_reg;
    logic        skid_sat_reg;
    logic        push;
    logic        pop;
    logic        load_out;

    assign en       = !skid_valid_reg;
    assign push     = en && xv_reg;
    assign pop      = out_valid_reg && res.ready;
    assign load_out = !out_valid_reg || pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= skid_valid_reg || push;
            end
            if (skid_valid_reg)
            begin
                skid_valid_reg <= !load_out;
            end
            else
            begin
                skid_valid_reg <= push && !load_out;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res_next;
            out_sat_reg <= skid_valid_reg ? skid_sat_reg : xside_reg.sat;
        end
        if (push && !load_out)
        begin
            skid_res_reg <= res_next;
            skid_sat_reg <= xside_reg.sat;
        end
    end

    assign arg.ready        = en;
    assign res.valid        = out_valid_reg;
    assign res.result_value = out_res_reg;
    assign res.saturated    = out_sat_reg;

    `IERF_ASSERT_NOW(a_skid_has_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `IERF_ASSERT_NOW(a_skid_blocks, skid_valid_reg, !arg.ready, "input open while skid full")
    `IERF_ASSERT_NOW(a_sat_clamp, out_valid_reg && out_sat_reg, out_res_reg == 32'h7FFF_FFFF || out_res_reg == 32'h8000_0000, "saturated beat not at full scale")
    `IERF_ASSERT_NXT(a_skid_drain, skid_valid_reg && res.ready, out_valid_reg && !skid_valid_reg, "skid did not drain")

endmodule
`default_nettype wire
